// ===== hw/rtl/pdte_pkg.sv =====
// Shared types, constants and month tables for the packed date to epoch seconds unit.
package pdte_pkg;

    localparam int unsigned DATE_W  = 27;
    localparam int unsigned TIME_W  = 20;
    localparam int unsigned EPOCH_W = 40;
    localparam int unsigned OFS_W   = 5;

    // Quotient and remainder widths of the divide-by-100 units
    localparam int unsigned QUO_W   = 21;
    localparam int unsigned REM_W   = 7;
    localparam int unsigned PROD_W  = 53;
    localparam int unsigned RECIP_W = 26;
    localparam int unsigned RECIP_SHIFT = 32;

    // floor(2^32 / 100): quotient estimate is exact or one short
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd100);
    localparam logic [7:0]         DEC_BASE  = 8'd100;

    localparam logic [14:0] EPOCH_YEAR     = 15'd1970;
    localparam logic [23:0] DAYS_PER_YEAR  = 24'd365;
    localparam logic [19:0] SECS_PER_HOUR  = 20'd3600;
    localparam logic [19:0] SECS_PER_MIN   = 20'd60;
    localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;

    localparam logic [6:0] SEC_MAX   = 7'd60;
    localparam logic [6:0] MIN_LIMIT = 7'd60;
    localparam logic [6:0] HOUR_LIMIT = 7'd24;
    localparam logic [6:0] MONTHS    = 7'd12;

    typedef logic [DATE_W-1:0]          t_date;
    typedef logic [TIME_W-1:0]          t_time;
    typedef logic signed [EPOCH_W-1:0]  t_epoch;
    typedef logic signed [OFS_W-1:0]    t_offset;
    typedef logic [QUO_W-1:0]           t_quo;
    typedef logic [REM_W-1:0]           t_rem;
    typedef logic [8:0]                 t_cum;

    // Days in the full months before month index n (0..12)
    localparam t_cum CUM_COMMON [13] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
                                         9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
    localparam t_cum CUM_LEAP   [13] = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
                                         9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

    function automatic t_cum cum_days(input logic [3:0] n, input logic leap);
        t_cum v;
        if (n > 4'd12) begin
            v = leap ? CUM_LEAP[12] : CUM_COMMON[12];
        end else begin
            v = leap ? CUM_LEAP[n] : CUM_COMMON[n];
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/pdte_if.sv =====
// Valid/ready channel interfaces for input words, result words and the offset register.
interface pdte_in_if
    import pdte_pkg::*;
();
    logic  valid;
    logic  ready;
    t_date date_packed;
    t_time time_packed;

    modport source (output valid, output date_packed, output time_packed, input ready);
    modport sink   (input valid, input date_packed, input time_packed, output ready);
endinterface

interface pdte_out_if
    import pdte_pkg::*;
();
    logic   valid;
    logic   ready;
    t_epoch epoch_seconds;
    logic   fields_bad;

    modport source (output valid, output epoch_seconds, output fields_bad, input ready);
    modport sink   (input valid, input epoch_seconds, input fields_bad, output ready);
endinterface

interface pdte_cfg_if
    import pdte_pkg::*;
();
    logic    valid;
    logic    ready;
    t_offset data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pdte_div100.sv =====
// Two-stage divide by 100: reciprocal multiply, then one correction step.
module pdte_div100
    import pdte_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_date i_x,
    output t_quo  o_q,
    output t_rem  o_r
);

    logic [PROD_W-1:0] r_prod;
    t_date             r_x;
    t_quo              r_q;
    t_rem              r_r;

    logic [PROD_W-1:0] n_prod;
    t_quo              q_est;
    logic [DATE_W:0]   diff;
    logic [7:0]        rem_est;
    t_quo              n_q;
    t_rem              n_r;

    // Estimate the quotient
    assign n_prod = PROD_W'(i_x) * PROD_W'(RECIP_100);

    // Fix up an estimate that falls one short
    assign q_est   = r_prod[RECIP_SHIFT +: QUO_W];
    assign diff    = (DATE_W+1)'(r_x) - ((DATE_W+1)'(q_est) * (DATE_W+1)'(DEC_BASE));
    assign rem_est = diff[7:0];

    always_comb begin
        if (rem_est >= DEC_BASE) begin
            n_q = q_est + QUO_W'(1);
            n_r = REM_W'(rem_est - DEC_BASE);
        end else begin
            n_q = q_est;
            n_r = REM_W'(rem_est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_x    <= i_x;
            r_q    <= n_q;
            r_r    <= n_r;
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

// ===== hw/rtl/pdte_calc.sv =====
// Three-stage calendar arithmetic: day count, time of day, then seconds.
module pdte_calc
    import pdte_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  logic [13:0] i_year,
    input  t_rem    i_mon,
    input  t_rem    i_day,
    input  t_rem    i_hour,
    input  t_rem    i_min,
    input  t_rem    i_sec,
    input  t_offset i_offset,
    output t_epoch  o_epoch,
    output logic    o_bad
);

    // Stage A: year terms, month sum, range flag
    logic signed [14:0] tyears;
    logic signed [14:0] shifted;
    logic signed [14:0] biased;
    logic signed [12:0] leaps_tr;
    logic               leap;
    logic [3:0]         full_months;
    logic signed [12:0] n_part;
    logic signed [23:0] n_ty365;
    logic signed [7:0]  n_hoff;
    logic               n_bad;

    logic signed [12:0] r_part;
    logic signed [23:0] r_ty365;
    logic signed [7:0]  r_hoff;
    t_rem               r_min;
    t_rem               r_sec;
    logic               r_bad_a;

    assign tyears   = $signed({1'b0, i_year}) - $signed(EPOCH_YEAR);
    assign shifted  = tyears + 15'sd2;
    assign biased   = shifted + (shifted[14] ? 15'sd3 : 15'sd0);
    assign leaps_tr = 13'(biased >>> 2);
    assign leap     = (shifted[1:0] == 2'b00);

    always_comb begin
        if (i_mon == '0) begin
            full_months = 4'd0;
        end else if (i_mon > MONTHS) begin
            full_months = 4'd12;
        end else begin
            full_months = 4'(i_mon - 7'd1);
        end
    end

    assign n_part  = $signed(13'(cum_days(full_months, leap))) + $signed(13'(i_day))
                   - 13'sd1 + leaps_tr - $signed(13'(leap));
    assign n_ty365 = 24'(tyears) * $signed(DAYS_PER_YEAR);
    assign n_hoff  = 8'(i_offset) + $signed({1'b0, i_hour});
    assign n_bad   = (i_sec > SEC_MAX) || (i_min >= MIN_LIMIT) || (i_hour >= HOUR_LIMIT)
                   || (i_mon == '0) || (i_mon > MONTHS) || (i_day == '0);

    // Stage B: total days and seconds into the day
    logic signed [23:0] n_days;
    logic signed [19:0] n_tsec;
    logic signed [23:0] r_days;
    logic signed [19:0] r_tsec;
    logic               r_bad_b;

    assign n_days = r_ty365 + 24'(r_part);
    assign n_tsec = 20'(r_hoff) * $signed(SECS_PER_HOUR)
                  + $signed(20'(r_min) * SECS_PER_MIN) + $signed(20'(r_sec));

    // Stage C: scale days to seconds and add the time of day
    logic signed [41:0] n_secs;
    t_epoch             r_epoch;
    logic               r_bad_c;

    assign n_secs = (42'(r_days) * 42'(SECS_PER_DAY)) + 42'(r_tsec);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part  <= n_part;
            r_ty365 <= n_ty365;
            r_hoff  <= n_hoff;
            r_min   <= i_min;
            r_sec   <= i_sec;
            r_bad_a <= n_bad;
            r_days  <= n_days;
            r_tsec  <= n_tsec;
            r_bad_b <= r_bad_a;
            r_epoch <= EPOCH_W'(n_secs);
            r_bad_c <= r_bad_b;
        end
    end

    assign o_epoch = r_epoch;
    assign o_bad   = r_bad_c;

endmodule

// ===== hw/rtl/packed_date_to_epoch_seconds_unit.sv =====
// Top level: packed date and time to signed epoch seconds, seven-stage pipeline.
//
// Takes one word per cycle while the output is not stalled; the pipeline is
// two divide-by-100 units in series (two stages each) and
// three stages of calendar arithmetic, the last holding the output register.
// A stalled output freezes the whole pipeline, so no word is lost or repeated.
// The time zone offset is written on its own channel, always ready, and must
// only be changed while no word is in flight. The leap rule is the simple
// every-fourth-year one and holds from 1901 to 2099.
module packed_date_to_epoch_seconds_unit
    import pdte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdte_in_if.sink    i_word,
    pdte_out_if.source o_word,
    pdte_cfg_if.sink   i_cfg
);

    localparam int unsigned DEPTH = 7;

    logic [DEPTH-1:0] r_valid;
    t_offset          r_offset;
    logic             stall;
    logic             en;

    // Freeze every stage while the result waits
    assign stall = r_valid[DEPTH-1] && !o_word.ready;
    assign en    = !stall;

    assign i_word.ready = en;
    assign i_cfg.ready  = 1'b1;

    // Advance valid bits and hold the offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_offset <= '0;
        end else begin
            if (en) begin
                r_valid <= {r_valid[DEPTH-2:0], i_word.valid};
            end
            if (i_cfg.valid) begin
                r_offset <= i_cfg.data;
            end
        end
    end

    // First split: date by 100 and time by 100
    t_quo date_q1;
    t_rem day_r;
    t_quo time_q1;
    t_rem sec_r;

    pdte_div100 u_div_date1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (i_word.date_packed),
        .o_q   (date_q1),
        .o_r   (day_r)
    );

    pdte_div100 u_div_time1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (DATE_W'(i_word.time_packed)),
        .o_q   (time_q1),
        .o_r   (sec_r)
    );

    // Second split: year and month, hour and minute
    t_quo year_q;
    t_rem mon_r;
    t_quo hour_q;
    t_rem min_r;

    pdte_div100 u_div_date2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (DATE_W'(date_q1)),
        .o_q   (year_q),
        .o_r   (mon_r)
    );

    pdte_div100 u_div_time2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (DATE_W'(time_q1)),
        .o_q   (hour_q),
        .o_r   (min_r)
    );

    // Delay day and second alongside the second split
    t_rem r_day_d1;
    t_rem r_day_d2;
    t_rem r_sec_d1;
    t_rem r_sec_d2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_day_d1 <= day_r;
            r_day_d2 <= r_day_d1;
            r_sec_d1 <= sec_r;
            r_sec_d2 <= r_sec_d1;
        end
    end

    // Calendar arithmetic and output register
    t_epoch epoch;
    logic   bad;

    pdte_calc u_calc (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_year   (year_q[13:0]),
        .i_mon    (mon_r),
        .i_day    (r_day_d2),
        .i_hour   (REM_W'(hour_q)),
        .i_min    (min_r),
        .i_sec    (r_sec_d2),
        .i_offset (r_offset),
        .o_epoch  (epoch),
        .o_bad    (bad)
    );

    assign o_word.valid         = r_valid[DEPTH-1];
    assign o_word.epoch_seconds = epoch;
    assign o_word.fields_bad    = bad;

endmodule

// ===== tb/packed_date_to_epoch_seconds_unit_test.sv =====
// Self-checking bench for the packed date to epoch seconds unit: table, random words, offsets.
`timescale 1ns / 100ps

module packed_date_to_epoch_seconds_unit_test;
    import pdte_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int WORDS_PER_PHASE = 170;

    // Calendar constants of the conversion
    localparam longint BASE_YEAR     = 1970;
    localparam longint DAYS_IN_YEAR  = 365;
    localparam longint SECS_IN_DAY   = 86400;
    localparam longint SECS_IN_HOUR  = 3600;
    localparam longint SECS_IN_MIN   = 60;
    localparam int     MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // Offsets for the random phases; the fifth phase draws its own
    localparam int PHASE_OFFSETS [6] = '{-12, 14, -16, 15, 7, 0};
    localparam int RANDOM_PHASE      = 4;

    typedef struct packed {
        t_epoch epoch_seconds;
        logic   fields_bad;
    } t_epoch_res;

    typedef struct packed {
        t_date      date_packed;
        t_time      time_packed;
        logic       typed;
        t_epoch_res res;
    } t_date_row;

    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} t_sink_mode;

    // Directed words; the result is typed in where it is plain, else predicted
    localparam int DIRECTED_ROWS = 24;
    localparam t_date_row DIRECTED [DIRECTED_ROWS] = '{
        '{27'd19700101, 20'd0,       1'b1, '{40'sd0,        1'b0}},
        '{27'd19700101, 20'd1,       1'b1, '{40'sd1,        1'b0}},
        '{27'd19700101, 20'd235959,  1'b1, '{40'sd86399,    1'b0}},
        '{27'd19700101, 20'd60,      1'b1, '{40'sd60,       1'b0}},
        '{27'd19700101, 20'd61,      1'b1, '{40'sd61,       1'b1}},
        '{27'd19700101, 20'd6000,    1'b1, '{40'sd3600,     1'b1}},
        '{27'd19700101, 20'd240000,  1'b1, '{40'sd86400,    1'b1}},
        '{27'd19700102, 20'd0,       1'b1, '{40'sd86400,    1'b0}},
        '{27'd19700100, 20'd0,       1'b1, '{-40'sd86400,   1'b1}},
        '{27'd19700001, 20'd0,       1'b1, '{40'sd0,        1'b1}},
        '{27'd19700201, 20'd0,       1'b1, '{40'sd2678400,  1'b0}},
        '{27'd19701301, 20'd0,       1'b1, '{40'sd31536000, 1'b1}},
        '{27'd19709901, 20'd0,       1'b1, '{40'sd31536000, 1'b1}},
        '{27'd19710101, 20'd0,       1'b1, '{40'sd31536000, 1'b0}},
        '{27'd19720229, 20'd120000,  1'b0, '0},
        '{27'd19720301, 20'd0,       1'b0, '0},
        '{27'd19700132, 20'd0,       1'b0, '0},
        '{27'd19691231, 20'd235959,  1'b0, '0},
        '{27'd0,        20'd0,       1'b0, '0},
        '{27'd99991231, 20'd235959,  1'b0, '0},
        '{27'd134217727, 20'd1048575, 1'b0, '0},
        '{27'd21000301, 20'd0,       1'b0, '0},
        '{27'd19000301, 20'd990099,  1'b0, '0},
        '{27'd20991231, 20'd999999,  1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pdte_in_if  in_ch ();
    pdte_out_if out_ch ();
    pdte_cfg_if cfg_ch ();

    packed_date_to_epoch_seconds_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (in_ch),
        .o_word  (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_epoch_res pending_epochs [$];
    t_offset    utc_offset;
    int         mismatches;
    int         burst_left;
    int         quiet_cycles;
    int         sink_left;
    int         sink_tick;
    t_sink_mode sink_mode;
    t_epoch_res want;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predict epoch seconds and the bad-field flag for one word
    function automatic t_epoch_res epoch_of(t_date d, t_time t, t_offset ofs);
        longint     dl, tl, sec, mins, hour, day, mon, year;
        longint     yrs, leaps, months, days, secs;
        logic       leap;
        t_epoch_res r;
        dl   = longint'(d);
        tl   = longint'(t);
        sec  = tl % 100;
        mins = (tl / 100) % 100;
        hour = tl / 10000;
        day  = dl % 100;
        mon  = (dl / 100) % 100;
        year = dl / 10000;
        // Leap count truncates toward zero, also before the base year
        yrs   = year - BASE_YEAR;
        leaps = (yrs + 2) / 4;
        leap  = ((yrs + 2) % 4) == 0;
        if (leap) begin
            leaps--;
        end
        // Months above twelve count as a whole year
        months = (mon - 1 > 12) ? 12 : mon - 1;
        days   = 0;
        for (int i = 0; i < months; i++) begin
            days += MONTH_LEN[i] + ((leap && i == 1) ? 1 : 0);
        end
        days += day - 1 + yrs * DAYS_IN_YEAR + leaps;
        secs = days * SECS_IN_DAY + (hour + longint'(ofs)) * SECS_IN_HOUR
               + mins * SECS_IN_MIN + sec;
        r.epoch_seconds = secs[EPOCH_W-1:0];
        r.fields_bad    = sec > 60 || mins >= 60 || hour >= 24 || mon < 1 || mon > 12
                          || day == 0;
        return r;
    endfunction

    // Mostly real calendar dates, the rest malformed or raw bit patterns
    function automatic t_date random_date();
        int unsigned y, m, d, lim;
        y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999) : $urandom_range(1901, 2099);
        m = $urandom_range(1, 12);
        lim = MONTH_LEN[m-1];
        if (m == 2 && ((int'(y) - 1970 + 2) % 4) == 0) begin
            lim++;
        end
        d = $urandom_range(1, lim);
        if ($urandom_range(0, 9) < 8) begin
            return t_date'(y * 10000 + m * 100 + d);
        end
        case ($urandom_range(0, 4))
            0: return t_date'($urandom);
            1: return t_date'($urandom_range(0, 99991231));
            2: return t_date'(y * 10000 + m * 100);
            3: return t_date'(y * 10000 + $urandom_range(0, 99) * 100 + $urandom_range(0, 99));
            default: return t_date'(y * 10000 + m * 100 + $urandom_range(lim, 99));
        endcase
    endfunction

    function automatic t_time random_time();
        int unsigned h, m, s;
        h = $urandom_range(0, 23);
        m = $urandom_range(0, 59);
        s = $urandom_range(0, 60);
        if ($urandom_range(0, 9) < 8) begin
            return t_time'(h * 10000 + m * 100 + s);
        end
        case ($urandom_range(0, 3))
            0: return t_time'($urandom);
            1: return t_time'($urandom_range(0, 999999));
            2: return t_time'($urandom_range(24, 99) * 10000 + m * 100 + s);
            default: return t_time'(h * 10000 + $urandom_range(0, 99) * 100
                                    + $urandom_range(0, 99));
        endcase
    endfunction

    // Offer one word in bursts with random gaps; enter and leave at a falling edge
    task automatic send_word(t_date d, t_time t, logic typed, t_epoch_res typed_res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        in_ch.date_packed = d;
        in_ch.time_packed = t;
        in_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_epochs.push_back(typed ? typed_res : epoch_of(d, t, utc_offset));
        burst_left--;
        @(negedge i_clk);
    endtask

    // Drain the pipeline, then write the offset register
    task automatic write_offset(t_offset v);
        in_ch.valid = 1'b0;
        burst_left  = 0;
        while (pending_epochs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_ch.data  = v;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        utc_offset = v;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Result ready follows a pattern of its own, switching mode now and then
    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_left = $urandom_range(8, 80);
        end
        sink_left--;
        sink_tick++;
        case (sink_mode)
            SINK_OPEN:     out_ch.ready = 1'b1;
            SINK_RANDOM:   out_ch.ready = $urandom_range(0, 3) != 0;
            SINK_PERIODIC: out_ch.ready = (sink_tick % 3) == 0;
            default:       out_ch.ready = $urandom_range(0, 15) == 0;
        endcase
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_epochs.size() == 0) begin
                $error("unexpected result word: epoch_seconds %0d, fields_bad %0b",
                       out_ch.epoch_seconds, out_ch.fields_bad);
                mismatches++;
            end else begin
                want = pending_epochs.pop_front();
                if (out_ch.epoch_seconds !== want.epoch_seconds) begin
                    $error("epoch_seconds: expected %0d, actual %0d",
                           want.epoch_seconds, out_ch.epoch_seconds);
                    mismatches++;
                end
                if (out_ch.fields_bad !== want.fields_bad) begin
                    $error("fields_bad: expected %0b, actual %0b",
                           want.fields_bad, out_ch.fields_bad);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.date_packed  = '0;
        in_ch.time_packed  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;
        utc_offset         = '0;
        mismatches         = 0;
        burst_left         = 0;
        quiet_cycles       = 0;
        sink_left          = 0;
        sink_tick          = 0;
        sink_mode          = SINK_OPEN;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table with the offset at its reset value
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_word(DIRECTED[i].date_packed, DIRECTED[i].time_packed,
                      DIRECTED[i].typed, DIRECTED[i].res);
        end

        // Random words under each offset setting
        for (int p = 0; p < 6; p++) begin
            write_offset((p == RANDOM_PHASE) ? t_offset'($urandom_range(0, 31))
                                             : t_offset'(PHASE_OFFSETS[p]));
            repeat (WORDS_PER_PHASE) send_word(random_date(), random_time(), 1'b0, '0);
        end

        // Drop valid and wait for the last results
        in_ch.valid = 1'b0;
        while (pending_epochs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
